FILE: rtl/cda_pkg.sv
// shared types and constants of the calendar date adder
`default_nettype none

package cda_pkg;

   // field widths
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_IN_W  = 14;
   localparam int YEAR_W     = 15;
   localparam int ADD_DAYS_W = 16;
   localparam int ADD_MON_W  = 10;
   localparam int ADD_YRS_W  = 14;

   // year remainder modulo the 400 year leap cycle
   localparam int REM_W = 14;
   localparam logic [REM_W-1:0] LEAP_CYCLE   = REM_W'(400);
   localparam logic [REM_W-1:0] LEAP_LAST    = REM_W'(399);
   localparam logic [REM_W-1:0] CENTURY_1    = REM_W'(100);
   localparam logic [REM_W-1:0] CENTURY_2    = REM_W'(200);
   localparam logic [REM_W-1:0] CENTURY_3    = REM_W'(300);

   // conditional subtract steps: 400 shifted by 5 down to 0 covers any 14 bit year
   localparam int RED_STEP_W = 3;
   localparam logic [RED_STEP_W-1:0] RED_FIRST = RED_STEP_W'(5);

   // month codes and lengths
   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
   localparam logic [MONTH_W:0]   MONTHS_PER_YEAR = (MONTH_W+1)'(12);

   localparam logic [DAY_W-1:0] LEN_LONG  = DAY_W'(31);
   localparam logic [DAY_W-1:0] LEN_SHORT = DAY_W'(30);
   localparam logic [DAY_W-1:0] LEN_LEAP  = DAY_W'(29);
   localparam logic [DAY_W-1:0] LEN_FEB   = DAY_W'(28);
   localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DAYS,
      ST_MONTHS,
      ST_YEARS,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic reduce;
      logic day_step;
      logic month_step;
      logic year_add;
   } cmd_type;

   typedef struct packed {
      logic red_last;
      logic days_zero;
      logic months_zero;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/cda_ctrl.sv
// sequencing state machine of the calendar date adder
`default_nettype none

module cda_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire cda_pkg::status_type status,
   output cda_pkg::cmd_type        cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   cda_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         cda_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = cda_pkg::ST_REDUCE;
            end
         end
         cda_pkg::ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (status.red_last) begin
               state_in = cda_pkg::ST_DAYS;
            end
         end
         cda_pkg::ST_DAYS: begin
            if (status.days_zero) begin
               state_in = cda_pkg::ST_MONTHS;
            end else begin
               cmd.day_step = 1'b1;
            end
         end
         cda_pkg::ST_MONTHS: begin
            if (status.months_zero) begin
               state_in = cda_pkg::ST_YEARS;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         cda_pkg::ST_YEARS: begin
            cmd.year_add = 1'b1;
            state_in     = cda_pkg::ST_RESPOND;
         end
         cda_pkg::ST_RESPOND: begin
            rsp_strobe = 1'b1;
            state_in   = cda_pkg::ST_IDLE;
         end
         default: begin
            state_in = cda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/cda_datapath.sv
// date registers, step counters and leap year tracking
`default_nettype none

module cda_datapath (
   input  wire logic                                clock,
   input  wire cda_pkg::cmd_type                    cmd,
   input  wire logic [cda_pkg::DAY_W-1:0]           start_day,
   input  wire logic [cda_pkg::MONTH_W-1:0]         start_month,
   input  wire logic [cda_pkg::YEAR_IN_W-1:0]       start_year,
   input  wire logic [cda_pkg::ADD_DAYS_W-1:0]      add_days,
   input  wire logic [cda_pkg::ADD_MON_W-1:0]       add_months,
   input  wire logic [cda_pkg::ADD_YRS_W-1:0]       add_years,
   output cda_pkg::status_type                      status,
   output logic [cda_pkg::DAY_W-1:0]                result_day,
   output logic [cda_pkg::MONTH_W-1:0]              result_month,
   output logic [cda_pkg::YEAR_W-1:0]               result_year
);

   logic [cda_pkg::DAY_W-1:0]      day_ff;
   logic [cda_pkg::MONTH_W-1:0]    month_ff;
   logic [cda_pkg::YEAR_W-1:0]     year_ff;
   logic [cda_pkg::REM_W-1:0]      rem_ff;
   logic [cda_pkg::RED_STEP_W-1:0] red_step_ff;
   logic [cda_pkg::ADD_DAYS_W-1:0] days_left_ff;
   logic [cda_pkg::ADD_MON_W-1:0]  months_left_ff;
   logic [cda_pkg::ADD_YRS_W-1:0]  years_ff;

   logic                           leap;
   logic [cda_pkg::DAY_W-1:0]      month_len;
   logic [cda_pkg::DAY_W:0]        day_inc;
   logic                           day_wrap;
   logic [cda_pkg::MONTH_W:0]      month_inc;
   logic                           year_carry;
   logic [cda_pkg::MONTH_W-1:0]    month_next;
   logic [cda_pkg::REM_W-1:0]      rem_next;
   logic [cda_pkg::REM_W-1:0]      red_sub;

   // leap rule on the year modulo 400
   assign leap = (rem_ff[1:0] == 2'b00) && (rem_ff != cda_pkg::CENTURY_1)
                 && (rem_ff != cda_pkg::CENTURY_2) && (rem_ff != cda_pkg::CENTURY_3);

   always_comb begin
      unique case (month_ff)
         cda_pkg::MONTH_FEB: month_len = leap ? cda_pkg::LEN_LEAP : cda_pkg::LEN_FEB;
         cda_pkg::MONTH_APR,
         cda_pkg::MONTH_JUN,
         cda_pkg::MONTH_SEP,
         cda_pkg::MONTH_NOV: month_len = cda_pkg::LEN_SHORT;
         default:            month_len = cda_pkg::LEN_LONG;
      endcase
   end

   assign day_inc    = {1'b0, day_ff} + 1'b1;
   assign day_wrap   = day_inc > {1'b0, month_len};
   assign month_inc  = {1'b0, month_ff} + 1'b1;
   assign year_carry = month_inc > cda_pkg::MONTHS_PER_YEAR;
   assign month_next = year_carry ? cda_pkg::MONTH_JAN : month_inc[cda_pkg::MONTH_W-1:0];
   assign rem_next   = (rem_ff == cda_pkg::LEAP_LAST) ? '0 : rem_ff + 1'b1;
   assign red_sub    = cda_pkg::LEAP_CYCLE << red_step_ff;

   assign status.red_last    = (red_step_ff == '0);
   assign status.days_zero   = (days_left_ff == '0);
   assign status.months_zero = (months_left_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_ff         <= start_day;
         month_ff       <= start_month;
         year_ff        <= {1'b0, start_year};
         rem_ff         <= start_year;
         red_step_ff    <= cda_pkg::RED_FIRST;
         days_left_ff   <= add_days;
         months_left_ff <= add_months;
         years_ff       <= add_years;
      end
      if (cmd.reduce) begin
         if (rem_ff >= red_sub) begin
            rem_ff <= rem_ff - red_sub;
         end
         red_step_ff <= red_step_ff - 1'b1;
      end
      if (cmd.day_step) begin
         days_left_ff <= days_left_ff - 1'b1;
         if (day_wrap) begin
            day_ff   <= cda_pkg::DAY_FIRST;
            month_ff <= month_next;
            if (year_carry) begin
               year_ff <= year_ff + 1'b1;
               rem_ff  <= rem_next;
            end
         end else begin
            day_ff <= day_inc[cda_pkg::DAY_W-1:0];
         end
      end
      if (cmd.month_step) begin
         months_left_ff <= months_left_ff - 1'b1;
         month_ff       <= month_next;
         if (year_carry) begin
            year_ff <= year_ff + 1'b1;
            rem_ff  <= rem_next;
         end
      end
      if (cmd.year_add) begin
         year_ff <= year_ff + {1'b0, years_ff};
      end
   end

   assign result_day   = day_ff;
   assign result_month = month_ff;
   assign result_year  = year_ff;

endmodule

`default_nettype wire

FILE: rtl/calendar_date_adder_unit.sv
// top level of the calendar date adder: controller plus datapath
//
// one date per command: a transfer is taken when start is high and busy is low, and the
// result shows on the rsp_ ports for exactly one cycle with rsp_strobe high; nothing can
// hold it off, so the receiver must take it in that cycle. from the start transfer to
// the strobe an item goes through the reduction of the start year modulo 400 for the
// leap rule, the day steps one day at a time, then the month steps one month at a time,
// a check each that the day count and the month count have run out, the year add and
// the strobe. busy stays high throughout and a new start is taken from the cycle after
// the strobe. the day is not clamped after months are added, and a month outside 1..12
// counts as 31 days long
`default_nettype none

module calendar_date_adder_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [cda_pkg::DAY_W-1:0]         req_start_day,
   input  wire logic [cda_pkg::MONTH_W-1:0]       req_start_month,
   input  wire logic [cda_pkg::YEAR_IN_W-1:0]     req_start_year,
   input  wire logic [cda_pkg::ADD_DAYS_W-1:0]    req_add_days,
   input  wire logic [cda_pkg::ADD_MON_W-1:0]     req_add_months,
   input  wire logic [cda_pkg::ADD_YRS_W-1:0]     req_add_years,
   output logic                                   rsp_strobe,
   output logic [cda_pkg::DAY_W-1:0]              rsp_result_day,
   output logic [cda_pkg::MONTH_W-1:0]            rsp_result_month,
   output logic [cda_pkg::YEAR_W-1:0]             rsp_result_year
);

   // command and status between the sequencer and the datapath
   cda_pkg::cmd_type    cmd;
   cda_pkg::status_type status;

   // sequencer: load, year reduction, day steps, month steps, year add, strobe
   cda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // date registers hold the result steady until the next load
   cda_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .start_day    (req_start_day),
      .start_month  (req_start_month),
      .start_year   (req_start_year),
      .add_days     (req_add_days),
      .add_months   (req_add_months),
      .add_years    (req_add_years),
      .status       (status),
      .result_day   (rsp_result_day),
      .result_month (rsp_result_month),
      .result_year  (rsp_result_year)
   );

endmodule

`default_nettype wire
